### sv/permutation_shuffle_token_generator_assert.svh
// Assertion macros used by the checker of the token generator.
`ifndef PERMUTATION_SHUFFLE_TOKEN_GENERATOR_ASSERT_SVH
`define PERMUTATION_SHUFFLE_TOKEN_GENERATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("token generator check failed");

// Next-cycle implication, disabled while reset is held.
`define PSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("token generator check failed");

`endif

### sv/psg_pkg.sv
// Types, constants and the base32 character map of the token generator.
package psg_pkg;

  localparam int PERM_DEPTH = 32;
  localparam int IDX_W      = $clog2(PERM_DEPTH);
  localparam int CHAR_W     = 7;

  localparam logic [IDX_W-1:0]  IDX_LAST     = IDX_W'(PERM_DEPTH - 1);
  localparam logic [IDX_W-1:0]  LETTER_COUNT = IDX_W'(26);
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;
  // '2' minus 26: digits follow the letters in the alphabet
  localparam logic [CHAR_W-1:0] DIGIT_OFFSET = 7'd24;

  localparam logic MODE_SEED     = 1'b0;
  localparam logic MODE_GENERATE = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] seed_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] token_char;
    logic              last;
  } out_item_t;

  // One access cycle of the permutation memory
  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] wr_data;
  } perm_req_t;

  // Map a permutation entry to its base32 ASCII character
  function automatic logic [CHAR_W-1:0] b32_char(input logic [IDX_W-1:0] v);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(v);
    if (v < LETTER_COUNT) begin
      return CHAR_UPPER_A + ext;
    end
    return ext + DIGIT_OFFSET;
  endfunction

endpackage

### sv/psg_perm_ram.sv
// Permutation memory: one write port, one registered read port, reset to identity.
module psg_perm_ram
  import psg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  perm_req_t        req,
  output logic [IDX_W-1:0] rd_data
);

  logic [IDX_W-1:0]      mem [PERM_DEPTH];
  logic [PERM_DEPTH-1:0] valid_r;
  logic [IDX_W-1:0]      rd_data_r;

  // Mark entries once written; an unwritten entry reads as its own index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // Write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= valid_r[req.rd_addr] ? mem[req.rd_addr] : req.rd_addr;
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/psg_ctrl.sv
// Sequencer: seed and keyless swap steps as read-read-write-write, then character readout.
module psg_ctrl
  import psg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  in_item_t         in_item,
  input  logic [IDX_W-1:0] rd_data,
  output perm_req_t        req,
  output logic             busy,
  output logic             out_strobe,
  output out_item_t        out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_WR_A,
    S_WR_B,
    S_OUT
  } state_t;

  state_t           state_r;
  logic             gen_r;
  logic [IDX_W-1:0] key_r;
  logic [IDX_W-1:0] a_r;
  logic [IDX_W-1:0] da_r;
  logic [IDX_W-1:0] ptr_r;
  logic [IDX_W-1:0] seed_pos_r;
  logic             out_vld_r;
  logic             out_last_r;
  logic [IDX_W-1:0] ptr_nxt;

  // New pointer from the first read entry
  assign ptr_nxt = ptr_r + rd_data + key_r;

  // Drive the memory from the current step
  always_comb begin
    req = '0;
    case (state_r)
      S_RD_A: begin
        req.rd_en   = 1'b1;
        req.rd_addr = a_r;
      end
      S_RD_B: begin
        req.rd_en   = 1'b1;
        req.rd_addr = ptr_nxt;
      end
      S_WR_A: begin
        req.wr_en   = 1'b1;
        req.wr_addr = a_r;
        req.wr_data = rd_data;
      end
      S_WR_B: begin
        req.wr_en   = 1'b1;
        req.wr_addr = ptr_r;
        req.wr_data = da_r;
      end
      S_OUT: begin
        req.rd_en   = 1'b1;
        req.rd_addr = a_r;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  // Hold state, pointers and the output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ptr_r      <= '0;
      seed_pos_r <= '0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            gen_r <= in_item.mode;
            if (in_item.mode == MODE_GENERATE) begin
              a_r   <= '0;
              key_r <= '0;
            end else begin
              a_r   <= seed_pos_r;
              key_r <= in_item.seed_byte[IDX_W-1:0];
            end
            state_r <= S_RD_A;
          end
        end
        S_RD_A: begin
          state_r <= S_RD_B;
        end
        S_RD_B: begin
          da_r    <= rd_data;
          ptr_r   <= ptr_nxt;
          state_r <= S_WR_A;
        end
        S_WR_A: begin
          state_r <= S_WR_B;
        end
        S_WR_B: begin
          if (gen_r == MODE_GENERATE) begin
            a_r <= a_r + 1'b1;
            state_r <= (a_r == IDX_LAST) ? S_OUT : S_RD_A;
          end else begin
            seed_pos_r <= seed_pos_r + 1'b1;
            state_r    <= S_IDLE;
          end
        end
        S_OUT: begin
          out_vld_r  <= 1'b1;
          out_last_r <= (a_r == IDX_LAST);
          a_r        <= a_r + 1'b1;
          if (a_r == IDX_LAST) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = out_vld_r;
  assign out_item.token_char = b32_char(rd_data);
  assign out_item.last       = out_last_r;

endmodule

### sv/permutation_shuffle_token_generator.sv
// Top level of the permutation shuffle token generator.
//
// Input channel: an item (in_item: mode, seed_byte) is taken at a rising edge
// where start is high and busy is low. Mode seed mixes seed_byte[4:0] into the
// 32-entry permutation; mode generate shuffles it once more and emits a token.
// Result channel: out_strobe marks one character (out_item: token_char, last)
// for a single cycle; the receiver cannot stall and must take it then.
// Each swap step runs through the permutation memory as read first entry,
// read second entry, write first, write second.
// A seed item runs one swap step and gives no result.
// A generate item runs 32 swap steps, then reads out one character per
// cycle; the last character carries the last flag, and busy is low again
// during the last strobe cycle.
// Reset (rst_n low, synchronous) restores the identity permutation through the
// memory's per-entry valid bits, and clears the swap pointer and seed position.
module permutation_shuffle_token_generator
  import psg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  perm_req_t        req;
  logic [IDX_W-1:0] rd_data;

  // Sequencer
  psg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_item),
    .rd_data    (rd_data),
    .req        (req),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // Permutation memory
  psg_perm_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data)
  );

endmodule

### sv/psg_checker.sv
// Port-level checker of the token generator and its bind.
`include "permutation_shuffle_token_generator_assert.svh"

module psg_checker
  import psg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  logic letter_ok;
  logic digit_ok;

  // Split the base32 alphabet into its letter and digit ranges
  assign letter_ok = (out_item.token_char >= CHAR_UPPER_A) &&
                     (out_item.token_char <= CHAR_UPPER_A + 7'd25);
  assign digit_ok  = (out_item.token_char >= DIGIT_OFFSET + 7'd26) &&
                     (out_item.token_char <= DIGIT_OFFSET + 7'd31);

  // An accepted item always occupies the block in the next cycle
  `PSG_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  // Characters of a token come back to back until the last one
  `PSG_ASSERT_NEXT(a_chars_contig, clk, rst_n, out_strobe && !out_item.last, out_strobe)
  // Nothing follows the last character directly
  `PSG_ASSERT_NEXT(a_last_ends, clk, rst_n, out_strobe && out_item.last, !out_strobe)
  // Every character is in the base32 alphabet
  `PSG_ASSERT_NOW(a_char_range, clk, rst_n, out_strobe, letter_ok || digit_ok)

endmodule

bind permutation_shuffle_token_generator psg_checker u_psg_checker (.*);
